// File: rtl/core/pflt_pkg.sv
package pflt_pkg;

    // Table geometry
    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);

    // Field widths of the request and response words
    localparam int CMD_W  = 2;
    localparam int FILE_W = 16;
    localparam int PAGE_W = 31;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // One stored table entry
    typedef struct packed {
        logic [FILE_W-1:0] file_id;
        logic [PAGE_W-1:0] page_number;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic fin;
    } t_ctl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/pflt_if.sv
// Request channel: one command word per handshake.
interface pflt_req_if;
    import pflt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_number;
    logic [SLOT_W-1:0] slot_in;

    modport source (output valid, output cmd, output file_id, output page_number,
                    output slot_in, input ready);
    modport sink   (input valid, input cmd, input file_id, input page_number,
                    input slot_in, output ready);
endinterface

// Response channel: one result word per handshake.
interface pflt_rsp_if;
    import pflt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;

    modport source (output valid, output status, output slot_out, input ready);
    modport sink   (input valid, input status, input slot_out, output ready);
endinterface

// File: rtl/core/pflt_ctrl.sv
module pflt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pflt_pkg::t_sts  i_sts,
    output pflt_pkg::t_ctl  o_ctl
);
    import pflt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // A new word is taken only between operations.
    assign o_in_ready = (r_state == S_IDLE);

    // Next-state logic and datapath commands.
    always_comb begin
        n_state   = r_state;
        o_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                // Update the table and register the result once the output is free.
                if (i_sts.out_free) begin
                    o_ctl.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_load_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");
    a_drain_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_FIN))
        else $error("drain cycle not followed by finish");
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !i_sts.out_free) |=> (r_state == S_FIN))
        else $error("finish left while the output register was occupied");
`endif

endmodule

// File: rtl/core/pflt_dpath.sv
module pflt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pflt_pkg::t_ctl                i_ctl,
    output pflt_pkg::t_sts                o_sts,
    input  logic [pflt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [pflt_pkg::FILE_W-1:0]   i_file_id,
    input  logic [pflt_pkg::PAGE_W-1:0]   i_page_number,
    input  logic [pflt_pkg::SLOT_W-1:0]   i_slot_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pflt_pkg::STAT_W-1:0]   o_status,
    output logic [pflt_pkg::SLOT_W-1:0]   o_slot_out
);
    import pflt_pkg::*;

    // Entry store and per-entry valid bits
    t_entry              r_mem [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;

    // Latched request
    logic [CMD_W-1:0]    r_cmd;
    t_entry              r_key;

    // Scan pipeline
    logic [ADDR_W-1:0]   r_scan_addr;
    logic                r_p_live;
    logic                r_p_vbit;
    logic [ADDR_W-1:0]   r_p_addr;
    t_entry              r_rd_data;

    // Search results
    logic                r_hit;
    logic [ADDR_W-1:0]   r_hit_idx;
    logic [SLOT_W-1:0]   r_hit_slot;
    logic                r_free_found;
    logic [ADDR_W-1:0]   r_free_idx;

    // Output register
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [SLOT_W-1:0]   r_slot_out;

    logic                key_match;
    logic [STAT_W-1:0]   res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic                wr_en;
    logic                clr_en;

    assign o_sts.scan_last = (r_scan_addr == ADDR_W'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign key_match = r_p_live && r_p_vbit
                    && (r_rd_data.file_id == r_key.file_id)
                    && (r_rd_data.page_number == r_key.page_number);

    // Latch the request word and step the scan address.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd             <= i_cmd;
            r_key.file_id     <= i_file_id;
            r_key.page_number <= i_page_number;
            r_key.slot        <= i_slot_in;
            r_scan_addr       <= '0;
        end else if (i_ctl.scan && !o_sts.scan_last) begin
            r_scan_addr <= r_scan_addr + ADDR_W'(1);
        end
    end

    // Entry memory: one registered read at the scan address, one write port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_scan_addr];
        if (wr_en) begin
            r_mem[r_free_idx] <= r_key;
        end
    end

    // Compare stage bookkeeping, aligned with the registered read.
    always_ff @(posedge i_clk) begin
        r_p_vbit <= r_valid[r_scan_addr];
        r_p_addr <= r_scan_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_live <= 1'b0;
        end else begin
            r_p_live <= i_ctl.scan;
        end
    end

    // Track the first matching entry and the lowest free entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_ctl.load) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (key_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (r_p_live && !r_p_vbit && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_match && !r_hit) begin
            r_hit_idx  <= r_p_addr;
            r_hit_slot <= r_rd_data.slot;
        end
        if (r_p_live && !r_p_vbit && !r_free_found) begin
            r_free_idx <= r_p_addr;
        end
    end

    // Result and table update for the finished command.
    always_comb begin
        res_status = ST_NOT_FOUND;
        res_slot   = '0;
        wr_en      = 1'b0;
        clr_en     = 1'b0;
        case (r_cmd)
            CMD_FIND: begin
                if (r_hit) begin
                    res_status = ST_OK;
                    res_slot   = r_hit_slot;
                end
            end
            CMD_INSERT: begin
                if (r_hit) begin
                    res_status = ST_PRESENT;
                end else if (r_free_found) begin
                    res_status = ST_OK;
                    wr_en      = i_ctl.fin;
                end else begin
                    res_status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (r_hit) begin
                    res_status = ST_OK;
                    clr_en     = i_ctl.fin;
                end
            end
            default: begin
                res_status = ST_NOT_FOUND;
            end
        endcase
    end

    // Valid bits: cleared together at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (wr_en) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    // Output register parts the table from the response channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_status   <= res_status;
            r_slot_out <= res_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot_out  = r_slot_out;

`ifndef SYNTHESIS
    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(r_free_idx)])
        else $error("inserted entry not marked valid");
    a_full_means_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fin && (res_status == ST_FULL)) |-> (&r_valid))
        else $error("table reported full with a free entry");
    a_hit_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fin && r_hit) |-> r_valid[r_hit_idx])
        else $error("matched entry is not valid");
    a_no_write_and_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && clr_en))
        else $error("insert and remove in the same finish");
`endif

endmodule

// File: rtl/core/page_frame_lookup_table_unit.sv
// Channel   Direction   Word                                     Handshake
// i_req     in          cmd, file_id, page_number, slot_in       valid / ready
// o_rsp     out         status, slot_out                         valid / ready
//
// A new word is accepted only once the previous one has finished. The entries
// are read one a cycle through the single read port, then a drain state empties
// the registered read and a finish state updates the table and the output.
// Reset clears every valid bit together; no clearing pass is needed.
// A result waiting on o_rsp does not block the next word; that word stalls in
// its update cycle only while the previous result is still untaken.
module page_frame_lookup_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pflt_req_if.sink  i_req,
    pflt_rsp_if.source o_rsp
);
    import pflt_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer
    pflt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // Entry store, search and result register
    pflt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_req.cmd),
        .i_file_id     (i_req.file_id),
        .i_page_number (i_req.page_number),
        .i_slot_in     (i_req.slot_in),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_slot_out    (o_rsp.slot_out)
    );

endmodule
